/* design/bcrf_pkg.sv */
package bcrf_pkg;

  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned IDX_W = $clog2(HEADER_BYTES);
  localparam logic [IDX_W-1:0] HEADER_LAST = IDX_W'(HEADER_BYTES - 1);

  localparam logic [7:0] MAGIC_RESET = 8'h80;
  localparam logic [7:0] SET_OP_RESET = 8'd1;
  localparam logic [7:0] GET_OP_RESET = 8'd0;
  localparam logic [7:0] GETK_OP_RESET = 8'd12;

  // configuration register indexes
  localparam logic [1:0] CFG_EXPECTED_MAGIC = 2'd0;
  localparam logic [1:0] CFG_SET_OPCODE = 2'd1;
  localparam logic [1:0] CFG_GET_OPCODE = 2'd2;
  localparam logic [1:0] CFG_GETK_OPCODE = 2'd3;

  // event kinds
  localparam logic [1:0] EV_FRAMED = 2'd0;
  localparam logic [1:0] EV_BAD_MAGIC = 2'd1;
  localparam logic [1:0] EV_BAD_OPCODE = 2'd2;
  localparam logic [1:0] EV_SHORT_BODY = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [31:0] request_id;
    logic [7:0]  request_opcode;
    logic [15:0] key_length;
  } out_item_t;

  typedef struct packed {
    logic [7:0] expected_magic;
    logic [7:0] set_opcode;
    logic [7:0] get_opcode;
    logic [7:0] getk_opcode;
  } cfg_t;

  // captured header fields plus the body arithmetic a store request needs
  typedef struct packed {
    logic [7:0]  magic;
    logic [7:0]  opcode;
    logic [15:0] key_len;
    logic [7:0]  extras_len;
    logic [31:0] request_id;
    logic        body_short;
    logic [31:0] value_len;
  } hdr_t;

endpackage

/* design/bcrf_hdr_capture.sv */
module bcrf_hdr_capture (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [bcrf_pkg::IDX_W-1:0] wr_index,
  input  logic [7:0]               wr_byte,
  output bcrf_pkg::hdr_t           hdr
);

  localparam int unsigned IW = bcrf_pkg::IDX_W;

  localparam logic [IW-1:0] HB_MAGIC = IW'(0);
  localparam logic [IW-1:0] HB_OPCODE = IW'(1);
  localparam logic [IW-1:0] HB_KEY_HI = IW'(2);
  localparam logic [IW-1:0] HB_KEY_LO = IW'(3);
  localparam logic [IW-1:0] HB_EXTRAS = IW'(4);
  localparam logic [IW-1:0] HB_BODY_3 = IW'(8);
  localparam logic [IW-1:0] HB_BODY_2 = IW'(9);
  localparam logic [IW-1:0] HB_BODY_1 = IW'(10);
  localparam logic [IW-1:0] HB_BODY_0 = IW'(11);
  localparam logic [IW-1:0] HB_ID_0 = IW'(12);
  localparam logic [IW-1:0] HB_ID_1 = IW'(13);
  localparam logic [IW-1:0] HB_ID_2 = IW'(14);
  localparam logic [IW-1:0] HB_ID_3 = IW'(15);

  logic [7:0]  magic;
  logic [7:0]  opcode;
  logic [15:0] key_len;
  logic [7:0]  extras_len;
  logic [31:0] total_len;
  logic [31:0] request_id;
  logic [16:0] need_len;

  // only the header bytes that are looked at are kept
  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case (wr_index)
        HB_MAGIC:  magic <= wr_byte;
        HB_OPCODE: opcode <= wr_byte;
        HB_KEY_HI: key_len[15:8] <= wr_byte;
        HB_KEY_LO: key_len[7:0] <= wr_byte;
        HB_EXTRAS: extras_len <= wr_byte;
        HB_BODY_3: total_len[31:24] <= wr_byte;
        HB_BODY_2: total_len[23:16] <= wr_byte;
        HB_BODY_1: total_len[15:8] <= wr_byte;
        HB_BODY_0: total_len[7:0] <= wr_byte;
        HB_ID_0:   request_id[7:0] <= wr_byte;
        HB_ID_1:   request_id[15:8] <= wr_byte;
        HB_ID_2:   request_id[23:16] <= wr_byte;
        HB_ID_3:   request_id[31:24] <= wr_byte;
        default: begin
        end
      endcase
    end
  end

  assign need_len = {1'b0, key_len} + {9'd0, extras_len};

  always_comb begin
    hdr.magic      = magic;
    hdr.opcode     = opcode;
    hdr.key_len    = key_len;
    hdr.extras_len = extras_len;
    hdr.request_id = request_id;
    hdr.body_short = total_len < {15'd0, need_len};
    hdr.value_len  = total_len - {15'd0, need_len};
  end

endmodule

/* design/bcrf_sequencer.sv */
module bcrf_sequencer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  bcrf_pkg::in_item_t         in_item,
  input  bcrf_pkg::cfg_t             cfg,
  input  bcrf_pkg::hdr_t             hdr,
  output logic                       hdr_wr_en,
  output logic [bcrf_pkg::IDX_W-1:0] hdr_wr_index,
  output logic                       result_valid,
  output bcrf_pkg::out_item_t        result
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_EXTRAS = 3'd1;
  localparam logic [2:0] PH_KEY = 3'd2;
  localparam logic [2:0] PH_VALUE = 3'd3;
  localparam logic [2:0] PH_DISCARD = 3'd4;

  logic [2:0]                 phase;
  logic [2:0]                 phase_next;
  logic [bcrf_pkg::IDX_W-1:0] header_index;
  logic [bcrf_pkg::IDX_W-1:0] header_index_next;
  logic [31:0]                bytes_remaining;
  logic [31:0]                bytes_remaining_next;

  logic [2:0]                 cur_phase;
  logic [bcrf_pkg::IDX_W-1:0] cur_index;
  logic                       op_known;
  logic                       emit;
  logic [1:0]                 kind;

  // start of stream forces this byte to be header byte 0
  assign cur_phase = in_item.start_of_stream ? PH_HEADER : phase;
  assign cur_index = in_item.start_of_stream ? '0 : header_index;

  assign op_known = (hdr.opcode == cfg.set_opcode) || (hdr.opcode == cfg.get_opcode) ||
                    (hdr.opcode == cfg.getk_opcode);

  assign hdr_wr_en    = accept && (cur_phase == PH_HEADER);
  assign hdr_wr_index = cur_index;

  always_comb begin
    phase_next           = cur_phase;
    header_index_next    = cur_index;
    bytes_remaining_next = bytes_remaining;
    emit                 = 1'b0;
    kind                 = bcrf_pkg::EV_FRAMED;

    if (cur_phase == PH_HEADER) begin
      if (cur_index != bcrf_pkg::HEADER_LAST) begin
        header_index_next = cur_index + {{(bcrf_pkg::IDX_W-1){1'b0}}, 1'b1};
      end else begin
        header_index_next = '0;
        if (hdr.magic != cfg.expected_magic) begin
          phase_next = PH_DISCARD;
          emit       = 1'b1;
          kind       = bcrf_pkg::EV_BAD_MAGIC;
        end else if (!op_known) begin
          phase_next = PH_DISCARD;
          emit       = 1'b1;
          kind       = bcrf_pkg::EV_BAD_OPCODE;
        end else begin
          phase_next           = PH_EXTRAS;
          bytes_remaining_next = {24'd0, hdr.extras_len};
        end
      end
    end else if (cur_phase != PH_DISCARD) begin
      if (bytes_remaining != 32'd0) begin
        bytes_remaining_next = bytes_remaining - 32'd1;
      end
    end

    // empty sections fall through within the same byte
    if (!emit && phase_next == PH_EXTRAS && bytes_remaining_next == 32'd0) begin
      phase_next           = PH_KEY;
      bytes_remaining_next = {16'd0, hdr.key_len};
    end
    if (!emit && phase_next == PH_KEY && bytes_remaining_next == 32'd0) begin
      if (hdr.opcode == cfg.set_opcode) begin
        if (hdr.body_short) begin
          phase_next = PH_DISCARD;
          emit       = 1'b1;
          kind       = bcrf_pkg::EV_SHORT_BODY;
        end else begin
          phase_next           = PH_VALUE;
          bytes_remaining_next = hdr.value_len;
        end
      end else begin
        phase_next           = PH_VALUE;
        bytes_remaining_next = 32'd0;
      end
    end
    if (!emit && phase_next == PH_VALUE && bytes_remaining_next == 32'd0) begin
      phase_next        = PH_HEADER;
      header_index_next = '0;
      emit              = 1'b1;
      kind              = bcrf_pkg::EV_FRAMED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_index    <= '0;
      bytes_remaining <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      header_index    <= header_index_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  assign result_valid = accept && emit;

  always_comb begin
    result.event_kind     = kind;
    result.request_id     = hdr.request_id;
    result.request_opcode = hdr.opcode;
    result.key_length     = hdr.key_len;
  end

endmodule

/* design/bcrf_out_skid.sv */
module bcrf_out_skid (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bcrf_pkg::out_item_t push_item,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output bcrf_pkg::out_item_t out_item
);

  logic                skid_valid;
  bcrf_pkg::out_item_t skid_item;
  logic                pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  // push never arrives while the skid stage is occupied
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_item <= skid_item;
      end else if (push) begin
        out_item <= push_item;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_item <= push_item;
      end else begin
        out_item <= push_item;
      end
    end
  end

endmodule

/* design/binary_cache_request_framer.sv */
// Frames binary cache requests from a byte stream, one byte per cycle unless
// stalled: each accepted byte updates the header capture and section counter in
// the cycle it arrives, and a framed-request or error item is registered for the
// output. The 24-byte header is checked for magic, then opcode, on its last byte;
// zero-length extras, key and value sections are passed over in the same cycle,
// so a bare request is framed on its last header byte. A store request's body is
// checked against key plus extras on the byte that ends the key. After an error
// every byte is dropped until one arrives with start_of_stream set. A two-entry
// output stage lets input keep flowing while one result waits; in_stall rises
// only when two results are held. Configuration writes take effect on the next
// cycle and should be made while no request is in flight.
module binary_cache_request_framer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bcrf_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output bcrf_pkg::out_item_t out_item,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  bcrf_pkg::cfg_t             cfg;
  bcrf_pkg::hdr_t             hdr;
  bcrf_pkg::out_item_t        result;
  logic                       accept;
  logic                       hdr_wr_en;
  logic [bcrf_pkg::IDX_W-1:0] hdr_wr_index;
  logic                       result_valid;
  logic                       full;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_magic <= bcrf_pkg::MAGIC_RESET;
      cfg.set_opcode     <= bcrf_pkg::SET_OP_RESET;
      cfg.get_opcode     <= bcrf_pkg::GET_OP_RESET;
      cfg.getk_opcode    <= bcrf_pkg::GETK_OP_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bcrf_pkg::CFG_EXPECTED_MAGIC: cfg.expected_magic <= cfg_data;
        bcrf_pkg::CFG_SET_OPCODE:     cfg.set_opcode <= cfg_data;
        bcrf_pkg::CFG_GET_OPCODE:     cfg.get_opcode <= cfg_data;
        bcrf_pkg::CFG_GETK_OPCODE:    cfg.getk_opcode <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bcrf_hdr_capture u_hdr_capture (
    .clk      (clk),
    .wr_en    (hdr_wr_en),
    .wr_index (hdr_wr_index),
    .wr_byte  (in_item.data_byte),
    .hdr      (hdr)
  );

  bcrf_sequencer u_sequencer (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_item      (in_item),
    .cfg          (cfg),
    .hdr          (hdr),
    .hdr_wr_en    (hdr_wr_en),
    .hdr_wr_index (hdr_wr_index),
    .result_valid (result_valid),
    .result       (result)
  );

  bcrf_out_skid u_out_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (result_valid),
    .push_item (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
